[design/ngfm_pkg.sv]
// shared constants, control word type and microcode table for the grid field match unit
`default_nettype none

package ngfm_pkg;

  // grid geometry
  localparam int GRID_HALF  = 10;
  localparam int GRID_SIDE  = 2 * GRID_HALF + 1;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int COORD_W    = 5;
  localparam int IDX_W      = $clog2(GRID_SIDE);
  localparam int ADDR_W     = $clog2(GRID_CELLS);

  // sample and distance widths
  localparam int FIELD_W     = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int DIST_W      = 34;
  localparam int WORD_W      = 3 * SAMPLE_BITS;

  localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-GRID_HALF);
  localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_HALF);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(GRID_SIDE - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(GRID_CELLS - 1);

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // microcode step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_WRITE = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;

  // jump conditions; the step holds until its condition is met
  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_ACCEPT    = 3'd1,
    COND_SCAN_END  = 3'd2,
    COND_PIPE_IDLE = 3'd3,
    COND_OUT_FREE  = 3'd4
  } cond_t;

  typedef struct packed {
    logic              in_ready;
    logic              mem_we;
    logic              scan_go;
    logic              out_load;
    logic              dispatch;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // read-only control store
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{in_ready: 1'b0, mem_we: 1'b0, scan_go: 1'b0, out_load: 1'b0,
          dispatch: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        c.in_ready = 1'b1;
        c.dispatch = 1'b1;
        c.cond     = COND_ACCEPT;
      end
      STEP_WRITE: begin
        c.mem_we = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
      STEP_SCAN: begin
        c.scan_go = 1'b1;
        c.cond    = COND_SCAN_END;
        c.target  = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        c.cond   = COND_PIPE_IDLE;
        c.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.out_load = 1'b1;
        c.cond     = COND_OUT_FREE;
        c.target   = STEP_IDLE;
      end
      default: begin
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/nearest_grid_field_match_unit.sv]
// nearest grid field match unit: microcoded nearest entry search over a field grid
//
// Holds a 21 x 21 grid of expected three-axis field vectors in one table with a
// write port and a read port. A load transaction (kind = 0) writes one entry; a
// load whose grid_x or grid_y lies outside -10..10 is dropped. A query
// transaction (kind = 1) scans every entry, x outer and y inner, both ascending,
// one table read per cycle, through a three-stage read / square / compare
// pipeline, and returns the grid coordinates and squared distance of the
// nearest entry, the first one found on a tie. A query is accepted, reads every
// table entry, drains the pipeline and loads the result register. Loads make
// no result. The result register frees the input side, so the next transaction
// is taken while a result still waits. Entries must be loaded before a query
// reads them.
`default_nettype none

module nearest_grid_field_match_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  kind,
  input  wire logic signed [ngfm_pkg::COORD_W-1:0]   grid_x,
  input  wire logic signed [ngfm_pkg::COORD_W-1:0]   grid_y,
  input  wire logic signed [ngfm_pkg::FIELD_W-1:0]   entry_x,
  input  wire logic signed [ngfm_pkg::FIELD_W-1:0]   entry_y,
  input  wire logic signed [ngfm_pkg::FIELD_W-1:0]   entry_z,
  input  wire logic signed [ngfm_pkg::FIELD_W-1:0]   field_x,
  input  wire logic signed [ngfm_pkg::FIELD_W-1:0]   field_y,
  input  wire logic signed [ngfm_pkg::FIELD_W-1:0]   field_z,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [ngfm_pkg::COORD_W-1:0]        best_x,
  output logic signed [ngfm_pkg::COORD_W-1:0]        best_y,
  output logic        [ngfm_pkg::DIST_W-1:0]         best_distance_sq
);

  import ngfm_pkg::*;

  // sequencer
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ctrl_t             ctrl;
  logic              cond_met;
  logic              accept;

  // captured transaction
  logic                    wr_ok;
  logic [ADDR_W-1:0]       waddr;
  logic [WORD_W-1:0]       wdata;
  logic signed [SAMPLE_BITS-1:0] qx, qy, qz;

  // write address of the incoming load
  logic [COORD_W-1:0] ux, uy;
  logic               in_range;
  logic [ADDR_W-1:0]  addr_in;

  // scan counters
  logic [ADDR_W-1:0] raddr;
  logic [IDX_W-1:0]  sx, sy;

  // pipeline
  logic [WORD_W-1:0] grid_mem [GRID_CELLS];
  logic              v1, v2;
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]  cx1, cy1, cx2, cy2;
  logic signed [DIFF_W-1:0]   dx, dy, dz;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [DIST_W-1:0] dist_sum;

  // running best
  logic              have;
  logic [DIST_W-1:0] best_d;
  logic [IDX_W-1:0]  best_cx, best_cy;

  // control word and next step
  assign ctrl     = ucode(pc);
  assign in_ready = ctrl.in_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:    cond_met = 1'b1;
      COND_ACCEPT:    cond_met = accept;
      COND_SCAN_END:  cond_met = (raddr == ADDR_LAST);
      COND_PIPE_IDLE: cond_met = !v1 && !v2;
      COND_OUT_FREE:  cond_met = !out_valid;
      default:        cond_met = 1'b0;
    endcase
    if (!cond_met) begin
      pc_next = pc;
    end else if (ctrl.dispatch) begin
      pc_next = (kind == KIND_QUERY) ? STEP_SCAN : STEP_WRITE;
    end else begin
      pc_next = ctrl.target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // load address: (x + half) * side + (y + half)
  assign ux       = grid_x + COORD_W'(GRID_HALF);
  assign uy       = grid_y + COORD_W'(GRID_HALF);
  assign in_range = (grid_x >= COORD_MIN) && (grid_x <= COORD_MAX) &&
                    (grid_y >= COORD_MIN) && (grid_y <= COORD_MAX);
  assign addr_in  = ADDR_W'(ADDR_W'(ux) * ADDR_W'(GRID_SIDE)) + ADDR_W'(uy);

  // capture the transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_ok <= in_range;
      waddr <= addr_in;
      wdata <= {entry_x[SAMPLE_BITS-1:0], entry_y[SAMPLE_BITS-1:0],
                entry_z[SAMPLE_BITS-1:0]};
      qx    <= field_x[SAMPLE_BITS-1:0];
      qy    <= field_y[SAMPLE_BITS-1:0];
      qz    <= field_z[SAMPLE_BITS-1:0];
    end
  end

  // scan counters, x outer and y inner
  always_ff @(posedge clk) begin
    if (accept) begin
      raddr <= '0;
      sx    <= '0;
      sy    <= '0;
    end else if (ctrl.scan_go) begin
      raddr <= raddr + ADDR_W'(1);
      if (sy == IDX_LAST) begin
        sy <= '0;
        sx <= sx + IDX_W'(1);
      end else begin
        sy <= sy + IDX_W'(1);
      end
    end
  end

  // grid table, registered read every cycle, write on the write step
  always_ff @(posedge clk) begin
    if (ctrl.mem_we && wr_ok) begin
      grid_mem[waddr] <= wdata;
    end
    rd_data <= grid_mem[raddr];
    cx1     <= sx;
    cy1     <= sy;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.scan_go;
      v2 <= v1;
    end
  end

  // differences and squares
  assign dx = DIFF_W'($signed(rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS])) - DIFF_W'(qx);
  assign dy = DIFF_W'($signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS])) - DIFF_W'(qy);
  assign dz = DIFF_W'($signed(rd_data[SAMPLE_BITS-1:0])) - DIFF_W'(qz);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    sqx <= px[SQ_W-1:0];
    sqy <= py[SQ_W-1:0];
    sqz <= pz[SQ_W-1:0];
    cx2 <= cx1;
    cy2 <= cy1;
  end

  // sum and compare against the running best
  assign dist_sum = DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept) begin
      have <= 1'b0;
    end else if (v2) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && (!have || dist_sum < best_d)) begin
      best_d  <= dist_sum;
      best_cx <= cx2;
      best_cy <= cy2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load && !out_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && !out_valid) begin
      best_x           <= COORD_W'(best_cx) - COORD_W'(GRID_HALF);
      best_y           <= COORD_W'(best_cy) - COORD_W'(GRID_HALF);
      best_distance_sq <= best_d;
    end
  end

`ifndef NO_ASSERTIONS
  // compare stage only runs during a scan or its drain
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (pc == STEP_SCAN || pc == STEP_DRAIN))
    else $error("compare stage active outside a scan");

  // a load goes straight to the write step
  a_load_dispatch: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_LOAD) |=> (pc == STEP_WRITE))
    else $error("load did not dispatch to write");

  // a query goes to the scan with the counters at the start
  a_query_dispatch: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_QUERY) |=> (pc == STEP_SCAN && raddr == '0))
    else $error("query did not start the scan at entry zero");

  // emitting with a free result register returns to idle holding a result
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_EMIT && !out_valid) |=> (out_valid && pc == STEP_IDLE))
    else $error("result not loaded on emit");

  // scan counters and read address stay within the grid
  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_SCAN) |-> (sx <= IDX_LAST && sy <= IDX_LAST && raddr <= ADDR_LAST))
    else $error("scan counters out of range");
`endif

endmodule

`default_nettype wire

[bench/nearest_grid_field_match_unit_tb.sv]
`timescale 1ns / 1ps
// testbench for the nearest grid field match unit: queued stimulus, grid search predictor, checker
module nearest_grid_field_match_unit_tb;
  import ngfm_pkg::*;

  localparam int RUN_LIMIT    = 3000000;
  localparam int DRAIN_CYCLES = 460;
  localparam int IDLE_PCT     = 14;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 2500;
  localparam int HOLD_AT      = 40;
  localparam int RANDOM_OPS   = 900;

  typedef logic signed [FIELD_W-1:0] sample_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;

  typedef struct {
    logic    kind;
    coord_t  gx;
    coord_t  gy;
    sample_t ex;
    sample_t ey;
    sample_t ez;
    sample_t fx;
    sample_t fy;
    sample_t fz;
    bit      wait_idle;
  } grid_op_t;

  typedef struct {
    coord_t            bx;
    coord_t            by;
    logic [DIST_W-1:0] dist_sq;
  } nearest_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_LOAD;
  coord_t            grid_x = '0;
  coord_t            grid_y = '0;
  sample_t           entry_x = '0;
  sample_t           entry_y = '0;
  sample_t           entry_z = '0;
  sample_t           field_x = '0;
  sample_t           field_y = '0;
  sample_t           field_z = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  coord_t            best_x;
  coord_t            best_y;
  logic [DIST_W-1:0] best_distance_sq;

  // predictor copy of the field grid, indexed [x][y][axis]
  sample_t  field_grid [GRID_SIDE][GRID_SIDE][3];
  grid_op_t grid_ops[$];
  nearest_t nearest_due[$];
  grid_op_t cur_op;
  bit       pause_next = 1'b0;
  int       ops_accepted = 0;
  int       results_seen = 0;
  int       error_count = 0;
  int       reports = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  sample_t  recent_vec [8][3];
  int       recent_slot = 0;

  nearest_grid_field_match_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .grid_x           (grid_x),
    .grid_y           (grid_y),
    .entry_x          (entry_x),
    .entry_y          (entry_y),
    .entry_z          (entry_z),
    .field_x          (field_x),
    .field_y          (field_y),
    .field_z          (field_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .best_x           (best_x),
    .best_y           (best_y),
    .best_distance_sq (best_distance_sq)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // stretch of the run with no idling on either side
  function automatic bit quiet_stretch();
    return ops_accepted >= 700 && ops_accepted < 900;
  endfunction

  // nearest entry search, x outer and y inner, first entry kept on a tie
  function automatic nearest_t search_nearest(sample_t fx, sample_t fy, sample_t fz);
    nearest_t res;
    longint   best;
    longint   d;
    longint   dx;
    longint   dy;
    longint   dz;
    bit       have;
    have = 1'b0;
    best = 0;
    res.bx = coord_t'(-GRID_HALF);
    res.by = coord_t'(-GRID_HALF);
    for (int i = 0; i < GRID_SIDE; i++) begin
      for (int j = 0; j < GRID_SIDE; j++) begin
        dx = longint'(field_grid[i][j][0]) - longint'(fx);
        dy = longint'(field_grid[i][j][1]) - longint'(fy);
        dz = longint'(field_grid[i][j][2]) - longint'(fz);
        d = dx * dx + dy * dy + dz * dz;
        if (!have || d < best) begin
          have = 1'b1;
          best = d;
          res.bx = coord_t'(i - GRID_HALF);
          res.by = coord_t'(j - GRID_HALF);
        end
      end
    end
    res.dist_sq = best[DIST_W-1:0];
    return res;
  endfunction

  // update the grid copy or queue the expected answer for one accepted transaction
  task automatic accept_op(grid_op_t op);
    int x;
    int y;
    x = int'(op.gx);
    y = int'(op.gy);
    if (op.kind == KIND_LOAD) begin
      // loads outside the grid are dropped
      if (x >= -GRID_HALF && x <= GRID_HALF && y >= -GRID_HALF && y <= GRID_HALF) begin
        field_grid[x + GRID_HALF][y + GRID_HALF][0] = op.ex;
        field_grid[x + GRID_HALF][y + GRID_HALF][1] = op.ey;
        field_grid[x + GRID_HALF][y + GRID_HALF][2] = op.ez;
      end
    end else begin
      nearest_due.push_back(search_nearest(op.fx, op.fy, op.fz));
    end
  endtask

  // transaction with every coordinate and sample random; unused fields keep their noise
  function automatic grid_op_t noise_op();
    grid_op_t op;
    op.kind = KIND_LOAD;
    op.gx = coord_t'($urandom);
    op.gy = coord_t'($urandom);
    op.ex = sample_t'($urandom);
    op.ey = sample_t'($urandom);
    op.ez = sample_t'($urandom);
    op.fx = sample_t'($urandom);
    op.fy = sample_t'($urandom);
    op.fz = sample_t'($urandom);
    op.wait_idle = 1'b0;
    return op;
  endfunction

  task automatic add_op(grid_op_t op);
    op.wait_idle = pause_next;
    pause_next = 1'b0;
    grid_ops.push_back(op);
  endtask

  task automatic push_load(int x, int y, sample_t vx, sample_t vy, sample_t vz);
    grid_op_t op;
    op = noise_op();
    op.kind = KIND_LOAD;
    op.gx = coord_t'(x);
    op.gy = coord_t'(y);
    op.ex = vx;
    op.ey = vy;
    op.ez = vz;
    add_op(op);
    recent_vec[recent_slot][0] = vx;
    recent_vec[recent_slot][1] = vy;
    recent_vec[recent_slot][2] = vz;
    recent_slot = (recent_slot + 1) % 8;
  endtask

  task automatic push_query(sample_t vx, sample_t vy, sample_t vz);
    grid_op_t op;
    op = noise_op();
    op.kind = KIND_QUERY;
    op.fx = vx;
    op.fy = vy;
    op.fz = vz;
    add_op(op);
  endtask

  function automatic sample_t tiny_sample();
    return sample_t'($urandom_range(8) - 4);
  endfunction

  function automatic sample_t jitter(sample_t v);
    return sample_t'(v + sample_t'($urandom_range(64) - 32));
  endfunction

  // stimulus, reset and end of run
  initial begin
    int      x;
    int      y;
    int      r;
    int      s;
    bit      tiny;
    grid_op_t op;

    foreach (recent_vec[i, k]) recent_vec[i][k] = '0;

    // fill the whole grid before any query reads it
    for (x = -GRID_HALF; x <= GRID_HALF; x++) begin
      for (y = -GRID_HALF; y <= GRID_HALF; y++) begin
        push_load(x, y, S_MAX, S_MAX, S_MAX);
      end
    end

    // loads outside the grid must leave it untouched
    push_load(-16, -16, S_MIN, S_MIN, S_MIN);
    push_load(15, 15, S_MIN, S_MIN, S_MIN);
    push_load(11, 0, S_MIN, S_MIN, S_MIN);
    push_load(0, -11, S_MIN, S_MIN, S_MIN);
    push_load(-11, 5, S_MIN, S_MIN, S_MIN);
    // largest distance, then an exact hit, both tied over the whole grid
    push_query(S_MIN, S_MIN, S_MIN);
    push_query(S_MAX, S_MAX, S_MAX);
    // last entry in scan order, as an exact hit and as a narrow nearest
    push_load(10, 10, S_MIN, S_MIN, S_MIN);
    push_query(S_MIN, S_MIN, S_MIN);
    push_query(-16'sd1, -16'sd1, -16'sd1);
    // ties decided by x, then by y
    push_load(3, -4, '0, '0, '0);
    push_load(0, 0, '0, '0, '0);
    push_query('0, '0, 16'sd1);
    push_load(-5, 7, '0, '0, '0);
    push_load(-5, 2, '0, '0, '0);
    push_query(16'sd1, '0, '0);
    push_query(16'sd100, 16'sd100, 16'sd100);

    // random part, with two pauses until the block has drained
    pause_next = 1'b1;
    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k == RANDOM_OPS / 2) pause_next = 1'b1;
      tiny = ((k / 75) % 3) == 2;
      r = $urandom_range(99);
      if (r < 55) begin
        // load, now and then aimed outside the grid
        if ($urandom_range(7) == 0) begin
          x = int'(coord_t'($urandom));
          y = int'(coord_t'($urandom));
        end else begin
          x = $urandom_range(2 * GRID_HALF) - GRID_HALF;
          y = $urandom_range(2 * GRID_HALF) - GRID_HALF;
        end
        if (tiny) push_load(x, y, tiny_sample(), tiny_sample(), tiny_sample());
        else begin
          op = noise_op();
          push_load(x, y, op.ex, op.ey, op.ez);
        end
      end else begin
        s = $urandom_range(7);
        if (tiny) push_query(tiny_sample(), tiny_sample(), tiny_sample());
        else if (r < 78) begin
          op = noise_op();
          push_query(op.fx, op.fy, op.fz);
        end else begin
          push_query(jitter(recent_vec[s][0]), jitter(recent_vec[s][1]),
                     jitter(recent_vec[s][2]));
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (grid_ops.size() != 0 || in_valid || nearest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (nearest_due.size() != 0) begin
      $display("missing %0d results at end of run", nearest_due.size());
      error_count += nearest_due.size();
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // driver: offer queued transactions, hold each until accepted
  always @(posedge clk) begin
    bit offer;
    offer = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accept_op(cur_op);
        ops_accepted++;
      end
      if (in_valid && !in_ready) begin
        offer = 1'b1;
      end else if (grid_ops.size() != 0 &&
                   !(grid_ops[0].wait_idle && nearest_due.size() != 0) &&
                   (quiet_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
        cur_op = grid_ops.pop_front();
        offer = 1'b1;
        kind    <= cur_op.kind;
        grid_x  <= cur_op.gx;
        grid_y  <= cur_op.gy;
        entry_x <= cur_op.ex;
        entry_y <= cur_op.ey;
        entry_z <= cur_op.ez;
        field_x <= cur_op.fx;
        field_y <= cur_op.fy;
        field_z <= cur_op.fz;
      end
      in_valid <= offer;
    end
  end

  // monitor: check each result transaction and drive out_ready
  always @(posedge clk) begin
    nearest_t want;
    bit       ready_next;
    ready_next = 1'b0;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (nearest_due.size() == 0) begin
          error_count++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("unexpected result: x %0d y %0d dist_sq %0d",
                     best_x, best_y, best_distance_sq);
          end
        end else begin
          want = nearest_due.pop_front();
          if (best_x !== want.bx || best_y !== want.by || best_distance_sq !== want.dist_sq) begin
            error_count++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("mismatch on result %0d: expected x %0d y %0d dist_sq %0d, got x %0d y %0d dist_sq %0d",
                       results_seen, want.bx, want.by, want.dist_sq,
                       best_x, best_y, best_distance_sq);
            end
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (results_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else begin
        ready_next = quiet_stretch() || $urandom_range(99) >= IDLE_PCT;
      end
      out_ready <= ready_next;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

[nearest_grid_field_match_unit.f]
design/ngfm_pkg.sv
design/nearest_grid_field_match_unit.sv
bench/nearest_grid_field_match_unit_tb.sv
